FILE: design/skt_pkg.sv
// Shared types and constants for the sorted key table.
package skt_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;
    localparam int unsigned FUNC_W        = 3;
    localparam int unsigned KEY_W         = 32;
    localparam int unsigned PAY_W         = 32;
    localparam int unsigned POS_W         = 6;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned COUNT_W       = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_SEARCH = 3'd1,
        FN_DELETE = 3'd2,
        FN_HEAD   = 3'd3,
        FN_TAIL   = 3'd4,
        FN_READ   = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic                    capture;
        logic                    exec_insert;
        logic                    exec_delete;
        logic                    exec_shift;
        t_func                   func;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
        logic [POS_W-1:0]        position;
    } t_cell_cmd;

endpackage

FILE: design/skt_if.sv
// Request and response channel interfaces of the sorted key table.
interface skt_req_if;
    logic                                valid;
    logic                                ready;
    logic [skt_pkg::FUNC_W-1:0]          func;
    logic signed [skt_pkg::KEY_W-1:0]    key;
    logic [skt_pkg::PAY_W-1:0]           payload;
    logic [skt_pkg::POS_W-1:0]           position;

    modport source (output valid, func, key, payload, position, input ready);
    modport sink   (input valid, func, key, payload, position, output ready);
endinterface

interface skt_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [skt_pkg::STATUS_W-1:0]        status;
    logic signed [skt_pkg::KEY_W-1:0]    found_key;
    logic [skt_pkg::PAY_W-1:0]           found_payload;
    logic [skt_pkg::COUNT_W-1:0]         count;

    modport source (output valid, status, found_key, found_payload, count, input ready);
    modport sink   (input valid, status, found_key, found_payload, count, output ready);
endinterface

FILE: design/skt_cell.sv
// One table cell: holds one entry, compares it with the request key and shifts with its neighbors.
module skt_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                             i_clk,
    input  skt_pkg::t_cell_cmd               i_cmd,
    input  logic                             i_valid,
    input  logic                             i_next_valid,
    input  logic                             i_prev_less_now,
    input  logic                             i_prev_less,
    input  logic signed [skt_pkg::KEY_W-1:0] i_prev_key,
    input  logic [skt_pkg::PAY_W-1:0]        i_prev_payload,
    input  logic signed [skt_pkg::KEY_W-1:0] i_next_key,
    input  logic [skt_pkg::PAY_W-1:0]        i_next_payload,
    output logic                             o_less_now,
    output logic                             o_less,
    output logic                             o_sel,
    output logic signed [skt_pkg::KEY_W-1:0] o_key,
    output logic [skt_pkg::PAY_W-1:0]        o_payload
);

    logic signed [skt_pkg::KEY_W-1:0] r_key;
    logic signed [skt_pkg::KEY_W-1:0] n_key;
    logic [skt_pkg::PAY_W-1:0]        r_payload;
    logic [skt_pkg::PAY_W-1:0]        n_payload;
    logic                             r_less;
    logic                             r_sel;
    logic                             n_sel;
    logic                             eq_now;

    assign o_less_now = i_valid && ($signed(r_key) < $signed(i_cmd.key));
    assign eq_now     = i_valid && (r_key == i_cmd.key);

    always_comb begin
        unique case (i_cmd.func) inside
            skt_pkg::FN_SEARCH, skt_pkg::FN_DELETE: begin
                n_sel = eq_now && i_prev_less_now && !o_less_now;
            end
            skt_pkg::FN_HEAD: begin
                n_sel = i_valid && (INDEX == 32'd0);
            end
            skt_pkg::FN_TAIL: begin
                n_sel = i_valid && !i_next_valid;
            end
            skt_pkg::FN_READ: begin
                n_sel = i_valid && (32'(i_cmd.position) == INDEX);
            end
            default: begin
                n_sel = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        if (i_cmd.exec_insert) begin
            if (!r_less) begin
                if (i_prev_less) begin
                    n_key     = i_cmd.key;
                    n_payload = i_cmd.payload;
                end else begin
                    n_key     = i_prev_key;
                    n_payload = i_prev_payload;
                end
            end
        end else if ((i_cmd.exec_delete && !r_less) || i_cmd.exec_shift) begin
            n_key     = i_next_key;
            n_payload = i_next_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
        if (i_cmd.capture) begin
            r_less <= o_less_now;
            r_sel  <= n_sel;
        end
    end

    assign o_less    = r_less;
    assign o_sel     = r_sel;
    assign o_key     = r_key;
    assign o_payload = r_payload;

endmodule

FILE: design/sorted_key_table_core.sv
// Top level of the sorted key table: a row of entry cells and the request sequencer.
// A request beat passes the idle and execute states: in the accept cycle every cell compares
// its entry with the request and registers its flags; in the execute state the row shifts by
// one place on an insert, delete or head, the count updates and the result is loaded into the
// output register. A waiting result does not block the next request beat, but that request
// holds in the execute state until the output register is free. No clearing pass follows reset.
module sorted_key_table_core #(
    parameter int unsigned DEPTH = skt_pkg::DEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    skt_req_if.sink         i_req,
    skt_rsp_if.source       o_rsp
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    skt_pkg::t_state                  r_state;
    skt_pkg::t_state                  n_state;
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    skt_pkg::t_func                   r_func;
    logic signed [skt_pkg::KEY_W-1:0] r_key;
    logic [skt_pkg::PAY_W-1:0]        r_payload;

    logic                             r_out_valid;
    logic                             n_out_valid;
    skt_pkg::t_status                 r_out_status;
    skt_pkg::t_status                 n_out_status;
    logic signed [skt_pkg::KEY_W-1:0] r_out_key;
    logic signed [skt_pkg::KEY_W-1:0] n_out_key;
    logic [skt_pkg::PAY_W-1:0]        r_out_payload;
    logic [skt_pkg::PAY_W-1:0]        n_out_payload;
    logic [skt_pkg::COUNT_W-1:0]      r_out_count;
    logic [skt_pkg::COUNT_W-1:0]      n_out_count;

    skt_pkg::t_cell_cmd               cmd;
    logic                             req_ready;
    logic                             full;
    logic                             found;
    logic signed [skt_pkg::KEY_W-1:0] sel_key;
    logic [skt_pkg::PAY_W-1:0]        sel_payload;

    logic [DEPTH:0]                   valid_vec;
    logic [DEPTH-1:0]                 less_now_vec;
    logic [DEPTH-1:0]                 less_vec;
    logic [DEPTH-1:0]                 sel_vec;
    logic signed [skt_pkg::KEY_W-1:0] cell_key [DEPTH];
    logic [skt_pkg::PAY_W-1:0]        cell_payload [DEPTH];

    assign valid_vec[DEPTH] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                             prev_less_now;
        logic                             prev_less;
        logic signed [skt_pkg::KEY_W-1:0] prev_key;
        logic [skt_pkg::PAY_W-1:0]        prev_payload;
        logic signed [skt_pkg::KEY_W-1:0] next_key;
        logic [skt_pkg::PAY_W-1:0]        next_payload;

        assign valid_vec[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            assign prev_less_now = 1'b1;
            assign prev_less     = 1'b1;
            assign prev_key      = cmd.key;
            assign prev_payload  = cmd.payload;
        end else begin : g_body
            assign prev_less_now = less_now_vec[g-1];
            assign prev_less     = less_vec[g-1];
            assign prev_key      = cell_key[g-1];
            assign prev_payload  = cell_payload[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_key     = cell_key[g];
            assign next_payload = cell_payload[g];
        end else begin : g_inner
            assign next_key     = cell_key[g+1];
            assign next_payload = cell_payload[g+1];
        end

        skt_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk           (i_clk),
            .i_cmd           (cmd),
            .i_valid         (valid_vec[g]),
            .i_next_valid    (valid_vec[g+1]),
            .i_prev_less_now (prev_less_now),
            .i_prev_less     (prev_less),
            .i_prev_key      (prev_key),
            .i_prev_payload  (prev_payload),
            .i_next_key      (next_key),
            .i_next_payload  (next_payload),
            .o_less_now      (less_now_vec[g]),
            .o_less          (less_vec[g]),
            .o_sel           (sel_vec[g]),
            .o_key           (cell_key[g]),
            .o_payload       (cell_payload[g])
        );
    end

    // At most one cell is selected, so an OR across the row picks its entry.
    always_comb begin
        sel_key     = '0;
        sel_payload = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (sel_vec[i]) begin
                sel_key     = sel_key | cell_key[i];
                sel_payload = sel_payload | cell_payload[i];
            end
        end
    end

    assign found = |sel_vec;
    assign full  = (r_count == CW'(DEPTH));

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        req_ready     = 1'b0;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_status  = r_out_status;
        n_out_key     = r_out_key;
        n_out_payload = r_out_payload;
        n_out_count   = r_out_count;

        cmd.capture     = 1'b0;
        cmd.exec_insert = 1'b0;
        cmd.exec_delete = 1'b0;
        cmd.exec_shift  = 1'b0;
        cmd.func        = r_func;
        cmd.key         = r_key;
        cmd.payload     = r_payload;
        cmd.position    = i_req.position;

        unique case (r_state)
            skt_pkg::ST_IDLE: begin
                req_ready   = 1'b1;
                cmd.capture = i_req.valid;
                cmd.func    = skt_pkg::t_func'(i_req.func);
                cmd.key     = i_req.key;
                cmd.payload = i_req.payload;
                if (i_req.valid) begin
                    n_state = skt_pkg::ST_EXEC;
                end
            end
            skt_pkg::ST_EXEC: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state       = skt_pkg::ST_IDLE;
                    n_out_valid   = 1'b1;
                    n_out_status  = skt_pkg::STAT_NOT_FOUND;
                    n_out_key     = '0;
                    n_out_payload = '0;
                    case (r_func) inside
                        skt_pkg::FN_INSERT: begin
                            if (full) begin
                                n_out_status = skt_pkg::STAT_FULL;
                            end else begin
                                cmd.exec_insert = 1'b1;
                                n_count         = r_count + CW'(1);
                                n_out_status    = skt_pkg::STAT_OK;
                                n_out_key       = r_key;
                                n_out_payload   = r_payload;
                            end
                        end
                        skt_pkg::FN_SEARCH, skt_pkg::FN_DELETE, skt_pkg::FN_HEAD,
                        skt_pkg::FN_TAIL, skt_pkg::FN_READ: begin
                            if (found) begin
                                n_out_status  = skt_pkg::STAT_OK;
                                n_out_key     = sel_key;
                                n_out_payload = sel_payload;
                                if (r_func == skt_pkg::FN_DELETE) begin
                                    cmd.exec_delete = 1'b1;
                                end
                                if (r_func == skt_pkg::FN_HEAD) begin
                                    cmd.exec_shift = 1'b1;
                                end
                                if (r_func == skt_pkg::FN_DELETE || r_func == skt_pkg::FN_HEAD
                                        || r_func == skt_pkg::FN_TAIL) begin
                                    n_count = r_count - CW'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_count = skt_pkg::COUNT_W'(n_count);
                end
            end
            default: begin
                n_state = skt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skt_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.capture) begin
            r_func    <= skt_pkg::t_func'(i_req.func);
            r_key     <= i_req.key;
            r_payload <= i_req.payload;
        end
        r_out_status  <= n_out_status;
        r_out_key     <= n_out_key;
        r_out_payload <= n_out_payload;
        r_out_count   <= n_out_count;
    end

    assign i_req.ready         = req_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.found_key     = r_out_key;
    assign o_rsp.found_payload = r_out_payload;
    assign o_rsp.count         = r_out_count;

endmodule

FILE: design/skt_checker.sv
// Port-level checks on the sorted key table, bound to its top level.
module skt_checker #(
    parameter int unsigned DEPTH = skt_pkg::DEPTH_DEFAULT
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_req_valid,
    input logic                             i_req_ready,
    input logic                             i_rsp_valid,
    input logic                             i_rsp_ready,
    input logic [skt_pkg::STATUS_W-1:0]     i_rsp_status,
    input logic signed [skt_pkg::KEY_W-1:0] i_rsp_key,
    input logic [skt_pkg::PAY_W-1:0]        i_rsp_payload,
    input logic [skt_pkg::COUNT_W-1:0]      i_rsp_count
);

    a_one_request_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request beat accepted while the previous one is still in progress");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_key) && $stable(i_rsp_payload) && $stable(i_rsp_count)))
        else $error("stalled result beat changed");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == skt_pkg::STAT_OK
            || i_rsp_status == skt_pkg::STAT_NOT_FOUND || i_rsp_status == skt_pkg::STAT_FULL))
        else $error("result beat carries an undefined status");

    a_full_only_at_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status == skt_pkg::STAT_FULL)
            |-> (i_rsp_count == skt_pkg::COUNT_W'(DEPTH)))
        else $error("table reported full below its depth");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != skt_pkg::STAT_OK)
            |-> (i_rsp_key == '0 && i_rsp_payload == '0))
        else $error("failed operation returned a nonzero entry");

endmodule

bind sorted_key_table_core skt_checker #(
    .DEPTH (DEPTH)
) u_skt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_key     (o_rsp.found_key),
    .i_rsp_payload (o_rsp.found_payload),
    .i_rsp_count   (o_rsp.count)
);
